### hdl/sha_pkg.sv
// Package for the SHA-256 byte stream hasher: types, constants and round functions.
// No dependencies; used by every module in hdl/.
`default_nettype none
package sha_pkg;

  typedef enum logic [1:0] {
    CMD_ABSORB        = 2'd0,
    CMD_ABSORB_FINISH = 2'd1,
    CMD_FINISH        = 2'd2,
    CMD_NONE          = 2'd3
  } cmd_e;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PadOffset  = 56;

  typedef struct packed {
    logic       absorb;
    logic       finish;
    logic [7:0] data;
  } op_t;

  localparam logic [255:0] InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
          32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
          32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
          32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
          32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
          32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
          32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
          32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
          32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
          32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
          32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

### hdl/sha_front.sv
// Front end: accepts command transactions and turns them into absorb/finish ops.
// Depends on sha_pkg.
`default_nettype none
module sha_front #(
  parameter int unsigned QDepth = sha_pkg::QueueDepth
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  output logic                      s_tready_o,
  input  wire logic [15:0]          s_tdata_i,
  output logic                      op_valid_o,
  input  wire logic                 op_ready_i,
  output sha_pkg::op_t              op_o
);
  import sha_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  op_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  op_t            op_in;
  cmd_e           cmd;
  logic           push, pop;

  assign cmd = cmd_e'(s_tdata_i[1:0]);

  always_comb begin
    op_in.data   = s_tdata_i[9:2];
    op_in.absorb = (cmd == CMD_ABSORB) || (cmd == CMD_ABSORB_FINISH);
    op_in.finish = (cmd == CMD_ABSORB_FINISH) || (cmd == CMD_FINISH);
  end

  assign s_tready_o = (cnt_q != (PtrW+1)'(QDepth));
  // drop unused commands at the door
  assign push = s_tvalid_i && s_tready_o && (op_in.absorb || op_in.finish);
  assign op_valid_o = (cnt_q != '0);
  assign pop = op_valid_o && op_ready_i;
  assign op_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= op_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(QDepth-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(QDepth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QDepth)) else $error("queue overfill");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule
`default_nettype wire

### hdl/sha_back.sv
// Back end: block buffer, padding sequencer, one-round-per-cycle compressor, digest out.
// Depends on sha_pkg.
`default_nettype none
module sha_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        op_valid_i,
  output logic             op_ready_o,
  input  wire sha_pkg::op_t op_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o,
  output logic [2:0]       m_tuser_o,
  output logic             m_tlast_o
);
  import sha_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_ADD   = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  state_e       state_q, state_d;
  logic [31:0]  buf_q [16]; // block buffer, big-endian words, written per byte lane
  logic [60:0]  total_q;
  logic [31:0]  h_q [8];
  logic [31:0]  v_q [8];
  logic [31:0]  w_q [16];
  logic [5:0]   rnd_q;
  logic [5:0]   pos_q;    // padding write pointer
  logic         pad_q;    // finishing in progress
  logic         last_blk_q; // block being compressed is the final one
  logic         fin_pend_q; // absorb op also finishes
  logic [3:0]   ld_q;     // word loader index
  logic [2:0]   oi_q;
  logic [63:0]  bits;
  logic [31:0]  t1, t2, s0, s1, wn, big0, big1, ch, maj;
  logic [7:0]   pad_byte;

  assign bits = {total_q, 3'b000};
  assign op_ready_o = (state_q == ST_IDLE);

  // marker byte sits at the total offset, except where that offset lands in the
  // length field of a second pad block
  always_comb begin
    if (pos_q == total_q[5:0] && !(last_blk_q && pos_q >= 6'(PadOffset))) pad_byte = 8'h80;
    else if (pos_q < 6'(PadOffset) || !last_blk_q) pad_byte = 8'h00;
    else pad_byte = bits[8*(7-(pos_q-6'(PadOffset)))+:8];
  end

  always_comb begin
    big1 = rotr(v_q[4],6) ^ rotr(v_q[4],11) ^ rotr(v_q[4],25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + round_k(rnd_q) + w_q[0];
    big0 = rotr(v_q[0],2) ^ rotr(v_q[0],13) ^ rotr(v_q[0],22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
    s0   = rotr(w_q[1],7) ^ rotr(w_q[1],18) ^ (w_q[1] >> 3);
    s1   = rotr(w_q[14],17) ^ rotr(w_q[14],19) ^ (w_q[14] >> 10);
    wn   = s1 + w_q[9] + s0 + w_q[0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) state_d = (op_i.absorb && total_q[5:0] == 6'd63) ? ST_LOAD :
                                  (op_i.absorb ? (op_i.finish ? ST_PAD : ST_IDLE) : ST_PAD);
      end
      ST_PAD:   if (pos_q == 6'd63) state_d = ST_LOAD;
      ST_LOAD:  if (ld_q == 4'd15) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD:   state_d = (pad_q && last_blk_q) ? ST_OUT : (pad_q || fin_pend_q) ? ST_PAD : ST_IDLE;
      ST_OUT:   if (m_tready_i && oi_q == 3'd7) state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // buffer write: absorb byte or padding byte, first byte of a word in the top lane
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && op_valid_i && op_i.absorb)
      buf_q[total_q[5:2]][{~total_q[1:0], 3'b000} +: 8] <= op_i.data;
    else if (state_q == ST_PAD)
      buf_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= pad_byte;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        w_q[ld_q] <= buf_q[ld_q];
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wn;
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; total_q <= '0; rnd_q <= '0; pos_q <= '0; pad_q <= 1'b0;
      last_blk_q <= 1'b0; fin_pend_q <= 1'b0; ld_q <= '0; oi_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[32*i+:32];
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: if (op_valid_i) begin
          fin_pend_q <= op_i.absorb && op_i.finish;
          if (op_i.absorb) begin
            total_q <= total_q + 61'd1;
            pos_q   <= total_q[5:0] + 6'd1;
            last_blk_q <= 1'b0;
            pad_q   <= 1'b0;
          end else begin
            pos_q <= total_q[5:0];
            pad_q <= 1'b1;
            last_blk_q <= (total_q[5:0] < 6'(PadOffset));
          end
        end
        ST_PAD: pos_q <= pos_q + 6'd1;
        ST_LOAD: ld_q <= ld_q + 4'd1;
        ST_ROUND: rnd_q <= rnd_q + 6'd1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (!pad_q && fin_pend_q) begin
            // deferred finish after a full block; total now on a block boundary
            pad_q <= 1'b1; fin_pend_q <= 1'b0; pos_q <= '0; last_blk_q <= 1'b1;
          end else if (pad_q && !last_blk_q) begin
            pos_q <= '0; last_blk_q <= 1'b1;
          end
        end
        ST_OUT: if (m_tready_i) oi_q <= oi_q + 3'd1;
        ST_FIN: begin
          for (int i = 0; i < 8; i++) h_q[i] <= InitHash[32*i+:32];
          total_q <= '0; pad_q <= 1'b0; last_blk_q <= 1'b0; fin_pend_q <= 1'b0;
        end
        default: ;
      endcase
      // absorb-then-finish without a full block: start padding at the new offset
      if (state_q == ST_IDLE && op_valid_i && op_i.absorb && op_i.finish
          && total_q[5:0] != 6'd63) begin
        pad_q <= 1'b1; fin_pend_q <= 1'b0;
        last_blk_q <= (total_q[5:0] + 6'd1 < 6'(PadOffset));
      end
    end
  end

  // stream the digest words in order
  assign m_tvalid_o = (state_q == ST_OUT);
  assign m_tdata_o  = h_q[oi_q];
  assign m_tuser_o  = oi_q;
  assign m_tlast_o  = (oi_q == 3'd7);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !op_ready_o) else $error("output while accepting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == 6'd63) |=> state_q == ST_ADD) else $error("round count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
endmodule
`default_nettype wire

### hdl/sha256_byte_stream_hasher_unit.sv
// SHA-256 byte stream hasher top level: front command queue feeding the hash back end.
// Depends on sha_pkg, sha_front, sha_back.
// Operation: a transaction enters the queue, then an absorb writes one byte to the block
//   buffer; one that completes a 64-byte block is followed by 16 word loads, 64 rounds and
//   1 chaining add. A finish pads to the end of each pad block, compresses one or two
//   blocks, then streams 8 words. Throughput: one SHA-256 round per cycle from the single
//   round unit; no new byte is taken while it compresses, pads or streams a digest.
//   Reset is async active low and restores the initial hash values and a zero byte count.
`default_nettype none
module sha256_byte_stream_hasher_unit #(
  parameter int unsigned QDepth = sha_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [15:0] s_tdata_i,  // [1:0] command, [9:2] data_byte, rest zero
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o,  // [31:0] digest_word
  output logic [2:0]       m_tuser_o,  // [2:0] word_index
  output logic             m_tlast_o   // last_word
);
  import sha_pkg::*;

  op_t  op;
  logic op_valid, op_ready;

  // front: classify and queue commands
  sha_front #(.QDepth(QDepth)) u_front (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i,
    .op_valid_o(op_valid), .op_ready_i(op_ready), .op_o(op)
  );

  // back: buffer, pad, compress, emit digest
  sha_back u_back (
    .clk_i, .rst_ni, .op_valid_i(op_valid), .op_ready_o(op_ready), .op_i(op),
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tuser_o, .m_tlast_o
  );
endmodule
`default_nettype wire

### tb/sv/sha_digest_checker.sv
// Checker for the SHA-256 byte stream hasher: watches both stream channels, predicts digests.
// Depends on sha_pkg for the command codes.
`timescale 1ns / 100ps
module sha_digest_checker
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic [2:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          pending_words_o
);

  localparam logic [31:0] IvWords [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [31:0]  chain_q [8];
  logic [7:0]   block_q [64];
  logic [60:0]  msg_bytes_q;
  digest_word_t digest_words_q [$];
  int           fails;

  assign fail_count_o    = fails;
  assign pending_words_o = digest_words_q.size();

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_q[4*i], block_q[4*i+1], block_q[4*i+2], block_q[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = chain_q;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] += v[i];
  endtask

  task automatic absorb_byte(logic [7:0] b);
    int pos;
    pos = msg_bytes_q[5:0];
    block_q[pos] = b;
    msg_bytes_q++;
    if (pos == 63) compress_block();
  endtask

  // Pad, compress the tail, queue the eight digest words and return to the IV.
  task automatic finish_digest();
    logic [63:0] bit_len;
    int pos;
    digest_word_t dw;
    bit_len = {msg_bytes_q, 3'b000};
    pos = msg_bytes_q[5:0];
    block_q[pos] = 8'h80;
    pos++;
    if (pos > PadOffset) begin
      while (pos < 64) block_q[pos++] = 8'h00;
      compress_block();
      pos = 0;
    end
    while (pos < PadOffset) block_q[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) block_q[PadOffset + i] = bit_len[8*(7-i) +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      dw.word = chain_q[i]; dw.index = 3'(i); dw.last = (i == 7);
      digest_words_q.push_back(dw);
    end
    chain_q = IvWords;
    msg_bytes_q = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t exp_w;
    cmd_e cmd;
    if (!rst_ni) begin
      chain_q = IvWords;
      msg_bytes_q = '0;
      digest_words_q.delete();
      fails = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (digest_words_q.size() == 0) begin
          $display("%0t: unexpected digest word %h", $time, m_tdata_i);
          fails++;
        end else begin
          exp_w = digest_words_q.pop_front();
          if (m_tdata_i !== exp_w.word || m_tuser_i !== exp_w.index ||
              m_tlast_i !== exp_w.last) begin
            $display("%0t: digest mismatch: expected %h idx %0d last %0d, got %h idx %0d last %0d",
                     $time, exp_w.word, exp_w.index, exp_w.last,
                     m_tdata_i, m_tuser_i, m_tlast_i);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        cmd = cmd_e'(s_tdata_i[1:0]);
        case (cmd)
          CMD_ABSORB: absorb_byte(s_tdata_i[9:2]);
          CMD_ABSORB_FINISH: begin
            absorb_byte(s_tdata_i[9:2]);
            finish_digest();
          end
          CMD_FINISH: finish_digest();
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the SHA-256 hasher testbench: clock, reset, byte stimulus and verdict.
// Depends on sha_pkg, sha256_byte_stream_hasher_unit and sha_digest_checker.
`timescale 1ns / 100ps
module testbench;
  import sha_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk_i, rst_ni;
  logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
  logic [15:0] s_tdata;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  int          fail_count, pending_words, cycles;
  bit          calm;  // suppress idling on both sides

  sha256_byte_stream_hasher_unit dut (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata),
    .m_tuser_o(m_tuser), .m_tlast_o(m_tlast)
  );

  sha_digest_checker checker_u (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .m_tuser_i(m_tuser), .m_tlast_i(m_tlast),
    .fail_count_o(fail_count), .pending_words_o(pending_words)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: stall with a probability of about 36 percent unless calm.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 36);
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Send one transaction, with a random gap before it; hold until accepted.
  task automatic send_item(cmd_e cmd, logic [7:0] b);
    while (!calm && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, b, cmd};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_message(int len, bit finish_with_byte);
    for (int i = 0; i < len - 1; i++) send_item(CMD_ABSORB, 8'($urandom));
    if (finish_with_byte && len > 0) send_item(CMD_ABSORB_FINISH, 8'($urandom));
    else begin
      if (len > 0) send_item(CMD_ABSORB, 8'($urandom));
      send_item(CMD_FINISH, 8'($urandom));
    end
  endtask

  initial begin
    int sent, len, pick, drain;
    cycles = 0; calm = 0;
    s_tvalid = 1'b0; s_tdata = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, byte extremes, unused command, one-byte finish.
    send_item(CMD_FINISH, 8'hff);
    send_item(CMD_ABSORB, 8'h00);
    send_item(CMD_ABSORB, 8'hff);
    send_item(CMD_NONE, 8'h5a);
    send_item(CMD_ABSORB_FINISH, 8'haa);
    send_item(CMD_ABSORB_FINISH, 8'h55);
    send_item(CMD_NONE, 8'hff);
    send_item(CMD_FINISH, 8'h00);

    // Hold off until every digest word has drained.
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);

    // Lengths around the padding boundaries: 55 and 56 bytes, then a full 64.
    send_message(55, 0);
    send_message(56, 1);
    send_message(64, 0);
    sent = 185;

    // Random messages, mostly short, with a calm stretch in the middle.
    while (sent < 280) begin
      calm = (sent > 200 && sent < 245);
      pick = $urandom_range(9);
      if (pick == 0) len = $urandom_range(119, 60);
      else len = $urandom_range(12);
      if ($urandom_range(7) == 0) send_item(CMD_NONE, 8'($urandom));
      send_message(len, $urandom_range(1));
      sent += len + 1;
    end
    calm = 0;
    s_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 200) begin
      @(posedge clk_i);
      drain++;
    end
    if (fail_count == 0 && pending_words == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

### sha256_byte_stream_hasher_unit.f
hdl/sha_pkg.sv
hdl/sha_front.sv
hdl/sha_back.sv
hdl/sha256_byte_stream_hasher_unit.sv
tb/sv/sha_digest_checker.sv
tb/sv/testbench.sv
